FILE: hdl/assert_macros.svh
// Assertion macros for the checker file of the block.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, ignored while reset is high.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, ignored while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

// Next-cycle implication that is also checked across reset.
`define ASSERT_AFTER(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication across reset");

`endif

FILE: hdl/dmim_pkg.sv
// Package for the dijet invariant mass block: widths, queue item, states.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package dmim_pkg;
  localparam int MAX_JETS_DEF = 16;
  localparam int PT_W         = 11;
  localparam int MOM_W        = 16;
  localparam int SUM_W        = 17;
  localparam int SQ_W         = 34;
  localparam int BEST_W       = 36;
  localparam int ROOT_W       = 18;
  localparam int REM_W        = 22;
  localparam int MASS_W       = 16;
  localparam int QUEUE_DEPTH  = 2;
  localparam logic [PT_W-1:0] PT_THRESHOLD_RST = 11'd60;

  typedef struct packed {
    logic                    pass;
    logic                    last;
    logic signed [MOM_W-1:0] px;
    logic signed [MOM_W-1:0] py;
    logic signed [MOM_W-1:0] pz;
    logic        [MOM_W-1:0] energy;
  } jet_item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAIR,
    ST_DRAIN,
    ST_STORE,
    ST_SQRT,
    ST_OUT
  } back_state_t;
endpackage
`default_nettype wire

FILE: hdl/dijet_max_invariant_mass.sv
// Top level of the dijet invariant mass block: ports, field packing, front/queue/back.
// Depends on dmim_pkg, dmim_front, dmim_queue, dmim_back.
//
// Use:
//   s_axis carries one jet per transfer; s_axis_tlast marks the last jet of an event.
//   Each jet at or above pt_threshold (cfg_we/cfg_wdata) is paired with every earlier
//   stored jet (none if the store is full); the largest positive squared mass is kept.
//   m_axis carries one result per event, after the transfer with tlast:
//   floor(sqrt(max)) saturated to 16 bits, and a flag for jets lost to a full store.
// Timing:
//   A jet paired with k >= 1 stored jets reads the store one entry per cycle through a
//   four-stage mass pipeline, drained before the store write. A jet with nothing to
//   pair (first of the event, failing or dropped) passes idle, pair, drain and store
//   without issuing. The last jet adds 18 square root steps, then loads the result
//   register. A two-entry queue lets the sender run ahead of the back end.
// Reset:
//   rst clears the event state, the queue and the result valid flag, and sets the
//   threshold to 60. When m_axis_tready is low, hold the result; the back end
//   stalls on the next result only, and the queue then fills and drops s_axis_tready.
`timescale 1ns / 1ps
`default_nettype none
module dijet_max_invariant_mass #(
  parameter int MAX_JETS = dmim_pkg::MAX_JETS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [10:0] cfg_wdata,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // jet_pt[10:0], jet_px[26:11], jet_py[42:27], jet_pz[58:43], jet_energy[74:59], zero
  input  wire logic [79:0] s_axis_tdata,
  input  wire logic        s_axis_tlast,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // max_mass[15:0], jets_dropped[16], zero
  output logic [23:0]      m_axis_tdata
);
  logic                          push;
  logic                          pop;
  dmim_pkg::jet_item_t           push_item;
  dmim_pkg::jet_item_t           pop_item;
  dmim_pkg::queue_status_t       qstat;
  logic [dmim_pkg::MASS_W-1:0]   max_mass;
  logic                          jets_dropped;

  dmim_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_pt     (s_axis_tdata[10:0]),
    .in_px     (s_axis_tdata[26:11]),
    .in_py     (s_axis_tdata[42:27]),
    .in_pz     (s_axis_tdata[58:43]),
    .in_energy (s_axis_tdata[74:59]),
    .in_last   (s_axis_tlast),
    .qstat     (qstat),
    .push      (push),
    .push_item (push_item)
  );

  dmim_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .pop_item  (pop_item),
    .qstat     (qstat)
  );

  dmim_back #(
    .MAX_JETS (MAX_JETS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .qstat       (qstat),
    .pop         (pop),
    .pop_item    (pop_item),
    .out_valid   (m_axis_tvalid),
    .out_ready   (m_axis_tready),
    .out_mass    (max_mass),
    .out_dropped (jets_dropped)
  );

  // pack the result; upper bits stay zero
  assign m_axis_tdata = {7'd0, jets_dropped, max_mass};
endmodule
`default_nettype wire

FILE: hdl/dmim_front.sv
// Front end: threshold register, jet classification and queue push.
// Depends on dmim_pkg.
`timescale 1ns / 1ps
`default_nettype none
module dmim_front (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         cfg_we,
  input  wire logic [dmim_pkg::PT_W-1:0]    cfg_wdata,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic [dmim_pkg::PT_W-1:0]    in_pt,
  input  wire logic [dmim_pkg::MOM_W-1:0]   in_px,
  input  wire logic [dmim_pkg::MOM_W-1:0]   in_py,
  input  wire logic [dmim_pkg::MOM_W-1:0]   in_pz,
  input  wire logic [dmim_pkg::MOM_W-1:0]   in_energy,
  input  wire logic                         in_last,
  input  dmim_pkg::queue_status_t           qstat,
  output logic                              push,
  output dmim_pkg::jet_item_t               push_item
);
  logic [dmim_pkg::PT_W-1:0] pt_threshold;

  always_ff @(posedge clk) begin
    if (rst) begin
      pt_threshold <= dmim_pkg::PT_THRESHOLD_RST;
    end else if (cfg_we) begin
      pt_threshold <= cfg_wdata;
    end
  end

  assign in_ready = !qstat.full;
  assign push     = in_valid && !qstat.full;

  // classify: a jet passes at or above the threshold
  always_comb begin
    push_item.pass   = (in_pt >= pt_threshold);
    push_item.last   = in_last;
    push_item.px     = in_px;
    push_item.py     = in_py;
    push_item.pz     = in_pz;
    push_item.energy = in_energy;
  end
endmodule
`default_nettype wire

FILE: hdl/dmim_queue.sv
// Short queue of classified jets between the front and back ends.
// Depends on dmim_pkg.
`timescale 1ns / 1ps
`default_nettype none
module dmim_queue (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  input  dmim_pkg::jet_item_t     push_item,
  input  wire logic               pop,
  output dmim_pkg::jet_item_t     pop_item,
  output dmim_pkg::queue_status_t qstat
);
  localparam int QA_W = $clog2(dmim_pkg::QUEUE_DEPTH);
  localparam int QC_W = $clog2(dmim_pkg::QUEUE_DEPTH + 1);

  dmim_pkg::jet_item_t entries [dmim_pkg::QUEUE_DEPTH];
  logic [QA_W-1:0] wr_ptr;
  logic [QA_W-1:0] rd_ptr;
  logic [QC_W-1:0] count;
  logic [QC_W-1:0] count_next;

  always_comb begin
    count_next = count;
    if (push && !pop) begin
      count_next = count + 1'b1;
    end else if (pop && !push) begin
      count_next = count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      count <= count_next;
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  assign pop_item    = entries[rd_ptr];
  assign qstat.full  = (count == QC_W'(dmim_pkg::QUEUE_DEPTH));
  assign qstat.empty = (count == '0);
endmodule
`default_nettype wire

FILE: hdl/dmim_back.sv
// Back end: jet store, pair mass pipeline, running maximum, square root, result register.
// Depends on dmim_pkg.
`timescale 1ns / 1ps
`default_nettype none
module dmim_back #(
  parameter int MAX_JETS = dmim_pkg::MAX_JETS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  dmim_pkg::queue_status_t            qstat,
  output logic                               pop,
  input  dmim_pkg::jet_item_t                pop_item,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [dmim_pkg::MASS_W-1:0]        out_mass,
  output logic                               out_dropped
);
  localparam int IDX_W = $clog2(MAX_JETS);
  localparam int CNT_W = $clog2(MAX_JETS + 1);
  localparam int SC_W  = $clog2(dmim_pkg::ROOT_W);

  dmim_pkg::back_state_t state;
  dmim_pkg::back_state_t state_next;
  dmim_pkg::jet_item_t   cur;

  logic [CNT_W-1:0] jet_count;
  logic [CNT_W-1:0] rd_idx;
  logic             overflow_seen;
  logic [dmim_pkg::BEST_W-1:0] best;

  logic [dmim_pkg::MOM_W-1:0] mem_px [MAX_JETS];
  logic [dmim_pkg::MOM_W-1:0] mem_py [MAX_JETS];
  logic [dmim_pkg::MOM_W-1:0] mem_pz [MAX_JETS];
  logic [dmim_pkg::MOM_W-1:0] mem_e  [MAX_JETS];

  logic signed [dmim_pkg::MOM_W-1:0] rd_px, rd_py, rd_pz;
  logic        [dmim_pkg::MOM_W-1:0] rd_e;
  logic signed [dmim_pkg::SUM_W-1:0] sx, sy, sz;
  logic        [dmim_pkg::SUM_W-1:0] se;
  logic signed [dmim_pkg::SQ_W-1:0]  sqx, sqy, sqz;
  logic        [dmim_pkg::SQ_W-1:0]  sqe;
  logic        [dmim_pkg::BEST_W-1:0] psum, e2;
  logic        [dmim_pkg::BEST_W-1:0] m2;
  logic v1, v2, v3, v4;

  logic [dmim_pkg::BEST_W-1:0] sq_op;
  logic [dmim_pkg::REM_W-1:0]  sq_rem;
  logic [dmim_pkg::ROOT_W-1:0] sq_root;
  logic [SC_W-1:0]             sq_cnt;
  logic [dmim_pkg::REM_W-1:0]  rem_sh;
  logic [dmim_pkg::REM_W-1:0]  trial;
  logic                        sq_done;

  logic store_full;
  logic pair_go;
  logic issue;
  logic out_load;
  logic pipe_busy;

  assign store_full = (jet_count == CNT_W'(MAX_JETS));
  assign pair_go    = cur.pass && !store_full && (rd_idx < jet_count);
  assign pipe_busy  = v1 || v2 || v3 || v4;
  assign sq_done    = (sq_cnt == SC_W'(dmim_pkg::ROOT_W - 1));

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      dmim_pkg::ST_IDLE:  if (!qstat.empty) state_next = dmim_pkg::ST_PAIR;
      dmim_pkg::ST_PAIR:  if (!pair_go) state_next = dmim_pkg::ST_DRAIN;
      dmim_pkg::ST_DRAIN: if (!pipe_busy) state_next = dmim_pkg::ST_STORE;
      dmim_pkg::ST_STORE: state_next = cur.last ? dmim_pkg::ST_SQRT : dmim_pkg::ST_IDLE;
      dmim_pkg::ST_SQRT:  if (sq_done) state_next = dmim_pkg::ST_OUT;
      dmim_pkg::ST_OUT:   if (!out_valid || out_ready) state_next = dmim_pkg::ST_IDLE;
      default:            state_next = dmim_pkg::ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    pop      = 1'b0;
    issue    = 1'b0;
    out_load = 1'b0;
    unique case (state)
      dmim_pkg::ST_IDLE: pop      = !qstat.empty;
      dmim_pkg::ST_PAIR: issue    = pair_go;
      dmim_pkg::ST_OUT:  out_load = !out_valid || out_ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dmim_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // take the next jet from the queue
  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= pop_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_idx <= '0;
    end else if (pop) begin
      rd_idx <= '0;
    end else if (issue) begin
      rd_idx <= rd_idx + 1'b1;
    end
  end

  // store write, only once all pairs of this jet are done
  always_ff @(posedge clk) begin
    if (state == dmim_pkg::ST_STORE && cur.pass && !store_full) begin
      mem_px[jet_count[IDX_W-1:0]] <= cur.px;
      mem_py[jet_count[IDX_W-1:0]] <= cur.py;
      mem_pz[jet_count[IDX_W-1:0]] <= cur.pz;
      mem_e[jet_count[IDX_W-1:0]]  <= cur.energy;
    end
  end

  // registered store read
  always_ff @(posedge clk) begin
    rd_px <= mem_px[rd_idx[IDX_W-1:0]];
    rd_py <= mem_py[rd_idx[IDX_W-1:0]];
    rd_pz <= mem_pz[rd_idx[IDX_W-1:0]];
    rd_e  <= mem_e[rd_idx[IDX_W-1:0]];
  end

  // pair pipeline: sums, squares, magnitude sum
  always_ff @(posedge clk) begin
    sx   <= dmim_pkg::SUM_W'(cur.px) + dmim_pkg::SUM_W'(rd_px);
    sy   <= dmim_pkg::SUM_W'(cur.py) + dmim_pkg::SUM_W'(rd_py);
    sz   <= dmim_pkg::SUM_W'(cur.pz) + dmim_pkg::SUM_W'(rd_pz);
    se   <= dmim_pkg::SUM_W'(cur.energy) + dmim_pkg::SUM_W'(rd_e);
    sqx  <= sx * sx;
    sqy  <= sy * sy;
    sqz  <= sz * sz;
    sqe  <= se * se;
    psum <= dmim_pkg::BEST_W'($unsigned(sqx)) + dmim_pkg::BEST_W'($unsigned(sqy))
          + dmim_pkg::BEST_W'($unsigned(sqz));
    e2   <= dmim_pkg::BEST_W'(sqe);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      v1 <= issue;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  assign m2 = e2 - psum;

  // event state: running maximum, jet count, overflow flag
  always_ff @(posedge clk) begin
    if (rst) begin
      best          <= '0;
      jet_count     <= '0;
      overflow_seen <= 1'b0;
    end else if (out_load) begin
      best          <= '0;
      jet_count     <= '0;
      overflow_seen <= 1'b0;
    end else begin
      // drop non-positive squares
      if (v4 && !m2[dmim_pkg::BEST_W-1] && (m2 != '0) && (m2 > best)) begin
        best <= m2;
      end
      if (state == dmim_pkg::ST_STORE && cur.pass) begin
        if (store_full) begin
          overflow_seen <= 1'b1;
        end else begin
          jet_count <= jet_count + 1'b1;
        end
      end
    end
  end

  // digit-by-digit square root, two operand bits per cycle
  always_comb begin
    rem_sh = {sq_rem[dmim_pkg::REM_W-3:0], sq_op[dmim_pkg::BEST_W-1 -: 2]};
    trial  = dmim_pkg::REM_W'({sq_root, 2'b01});
  end

  always_ff @(posedge clk) begin
    if (state == dmim_pkg::ST_STORE) begin
      sq_op   <= best;
      sq_rem  <= '0;
      sq_root <= '0;
      sq_cnt  <= '0;
    end else if (state == dmim_pkg::ST_SQRT) begin
      sq_op  <= {sq_op[dmim_pkg::BEST_W-3:0], 2'b00};
      sq_cnt <= sq_cnt + 1'b1;
      if (rem_sh >= trial) begin
        sq_rem  <= rem_sh - trial;
        sq_root <= {sq_root[dmim_pkg::ROOT_W-2:0], 1'b1};
      end else begin
        sq_rem  <= rem_sh;
        sq_root <= {sq_root[dmim_pkg::ROOT_W-2:0], 1'b0};
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_mass    <= (sq_root[dmim_pkg::ROOT_W-1:dmim_pkg::MASS_W] != '0)
                   ? '1 : sq_root[dmim_pkg::MASS_W-1:0];
      out_dropped <= overflow_seen;
    end
  end
endmodule
`default_nettype wire

FILE: hdl/dmim_checker.sv
// Port-level checker for the dijet invariant mass block, bound to the top level.
// Depends on assert_macros.svh and dijet_max_invariant_mass.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module dmim_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [23:0] m_axis_tdata
);
  `ASSERT_NEXT(a_out_hold, clk, rst, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
  `ASSERT_NEXT(a_out_stable, clk, rst, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata))
  `ASSERT_IMPLY(a_out_pad, clk, rst, m_axis_tvalid, m_axis_tdata[23:17] == 7'd0)
  `ASSERT_AFTER(a_reset_quiet, clk, rst, !m_axis_tvalid)
endmodule

bind dijet_max_invariant_mass dmim_checker u_checker (.*);
`default_nettype wire

FILE: bench/tb_top.sv
// Self-checking bench for dijet_max_invariant_mass: directed events, then random events.
// Depends on dmim_pkg and the block RTL only.
`timescale 1ns / 1ps
module tb_top;
  localparam int NJET = 16;
  localparam int CYCLE_LIMIT = 400000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [10:0] cfg_wdata = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [79:0] s_axis_tdata = '0;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;

  typedef struct packed {
    logic [10:0] pt;
    logic [15:0] px;
    logic [15:0] py;
    logic [15:0] pz;
    logic [15:0] en;
    logic        last;
  } jet_t;

  typedef struct packed {
    logic [15:0] mass;
    logic        dropped;
  } mass_result_t;

  // Directed row: the jet plus, where obvious, the typed-in result.
  typedef struct {
    jet_t         jet;
    bit           has_fixed;
    mass_result_t fixed;
  } dir_row_t;

  dijet_max_invariant_mass u_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  always #5 clk = ~clk;

  // Predictor state: stored jets, count, best squared mass, overflow.
  logic signed [15:0] kept_px [NJET];
  logic signed [15:0] kept_py [NJET];
  logic signed [15:0] kept_pz [NJET];
  logic        [15:0] kept_en [NJET];
  int unsigned        kept_cnt;
  longint unsigned    best_m2;
  bit                 lost_jet;
  logic [10:0]        pt_min;

  mass_result_t expected_masses[$];
  int  errors = 0;
  int  table_errors = 0;
  int  results_seen = 0;
  int  events_sent;
  longint cycles = 0;
  bit  sink_busy;   // when set, receiver always ready (no-stall stretch)
  bit  src_busy;

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // Advance the event state by one jet; queue a result on the last jet.
  function automatic void predict_jet(jet_t j);
    longint sx, sy, sz, se, m2;
    longint unsigned root;
    mass_result_t r;
    if (j.pt >= pt_min) begin
      if (kept_cnt >= NJET) begin
        lost_jet = 1'b1;
      end else begin
        for (int k = 0; k < kept_cnt; k++) begin
          sx = longint'($signed(j.px)) + longint'(kept_px[k]);
          sy = longint'($signed(j.py)) + longint'(kept_py[k]);
          sz = longint'($signed(j.pz)) + longint'(kept_pz[k]);
          se = longint'(j.en) + longint'(kept_en[k]);
          m2 = se * se - (sx * sx + sy * sy + sz * sz);
          if (m2 > 0 && longint'(m2) > longint'(best_m2)) best_m2 = m2;
        end
        kept_px[kept_cnt] = j.px;
        kept_py[kept_cnt] = j.py;
        kept_pz[kept_cnt] = j.pz;
        kept_en[kept_cnt] = j.en;
        kept_cnt++;
      end
    end
    if (j.last) begin
      root = int_sqrt(best_m2);
      r.mass = (root > 65535) ? 16'hFFFF : root[15:0];
      r.dropped = lost_jet;
      expected_masses = {expected_masses, r};
      kept_cnt = 0;
      best_m2 = 0;
      lost_jet = 1'b0;
    end
  endfunction

  // Cycle counter and timeout.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t timeout", $time);
      $display("tb_top NOT OK");
      $finish;
    end
  end

  // Receiver: random stalls, hold ready high during the no-stall stretch.
  always @(posedge clk) begin
    if (rst) m_axis_tready <= 1'b0;
    else m_axis_tready <= sink_busy ? 1'b1 : ($urandom_range(99) >= 22);
  end

  // Check each result transfer against the oldest expectation.
  always @(posedge clk) begin
    mass_result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      results_seen++;
      if (expected_masses.size() == 0) begin
        $display("%0t unexpected result mass=%0d dropped=%0b", $time,
                 m_axis_tdata[15:0], m_axis_tdata[16]);
        errors++;
      end else begin
        want = expected_masses.pop_front();
        if (m_axis_tdata[15:0] !== want.mass) begin
          $display("%0t max_mass expected %0d actual %0d", $time, want.mass,
                   m_axis_tdata[15:0]);
          errors++;
        end
        if (m_axis_tdata[16] !== want.dropped) begin
          $display("%0t jets_dropped expected %0b actual %0b", $time, want.dropped,
                   m_axis_tdata[16]);
          errors++;
        end
      end
    end
  end

  // Send one jet: random idle cycles first unless src_busy, then hold until the transfer.
  task automatic send_jet(jet_t j);
    if (!src_busy) begin
      while ($urandom_range(99) < 22) begin
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
      end
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {5'd0, j.en, j.pz, j.py, j.px, j.pt};
    s_axis_tlast  <= j.last;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    predict_jet(j);
    if (j.last) events_sent++;
  endtask

  // Wait for every result, then let the back end settle before a register write.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (expected_masses.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic set_threshold(logic [10:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    pt_min = v;
  endtask

  function automatic jet_t rand_jet(bit last, bit wide);
    jet_t j;
    j.pt = (wide || $urandom_range(3) == 0) ? 11'($urandom_range(2047))
                                            : 11'($urandom_range(300));
    if (wide) begin
      j.px = 16'($urandom); j.py = 16'($urandom); j.pz = 16'($urandom);
      j.en = 16'($urandom);
    end else begin
      // Mostly physical jets: modest momenta, energy above |p|.
      j.px = 16'($signed($urandom_range(8000)) - 4000);
      j.py = 16'($signed($urandom_range(8000)) - 4000);
      j.pz = 16'($signed($urandom_range(20000)) - 10000);
      j.en = 16'($urandom_range(45000) + 12000);
    end
    j.last = last;
    return j;
  endfunction

  dir_row_t dir_rows[$];

  function automatic dir_row_t mk(logic [10:0] pt, logic [15:0] px, logic [15:0] py,
                                  logic [15:0] pz, logic [15:0] en, bit last,
                                  bit fx = 0, logic [15:0] m = 0, bit d = 0);
    dir_row_t r;
    r.jet = '{pt, px, py, pz, en, last};
    r.has_fixed = fx;
    r.fixed = '{m, d};
    return r;
  endfunction

  initial begin
    int n_items;
    int ev_len;
    jet_t one_jet;
    events_sent = 0;
    sink_busy = 0; src_busy = 0;
    kept_cnt = 0; best_m2 = 0; lost_jet = 0; pt_min = dmim_pkg::PT_THRESHOLD_RST;

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Lone last jet after reset: no pair, mass 0.
    dir_rows = {dir_rows, mk(11'd100, 16'd0, 16'd0, 16'd0, 16'd500, 1, 1, 16'd0, 0)};
    // Failing last jet: still a result of 0.
    dir_rows = {dir_rows, mk(11'd59, 16'd1, 16'd1, 16'd1, 16'd9, 1, 1, 16'd0, 0)};
    // Two jets at rest: mass = E1+E2 = 1000.
    dir_rows = {dir_rows, mk(11'd60, 16'd0, 16'd0, 16'd0, 16'd400, 0)};
    dir_rows = {dir_rows, mk(11'd2047, 16'd0, 16'd0, 16'd0, 16'd600, 1, 1, 16'd1000, 0)};
    // Large mass saturates: full energy, opposite extreme momenta.
    dir_rows = {dir_rows, mk(11'd2047, 16'h8000, 16'h7FFF, 16'h8000, 16'hFFFF, 0)};
    dir_rows = {dir_rows, mk(11'd2047, 16'h7FFF, 16'h8000, 16'h7FFF, 16'hFFFF, 1)};
    // Negative square ignored: huge momentum, little energy.
    dir_rows = {dir_rows, mk(11'd500, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'd10, 0)};
    dir_rows = {dir_rows, mk(11'd500, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'd10, 1, 1, 16'd0, 0)};
    // Light-like pair: zero square.
    dir_rows = {dir_rows, mk(11'd100, 16'd300, 16'd0, 16'd400, 16'd500, 0)};
    dir_rows = {dir_rows, mk(11'd100, 16'd300, 16'd0, 16'd400, 16'd500, 1, 1, 16'd0, 0)};

    foreach (dir_rows[i]) begin
      send_jet(dir_rows[i].jet);
      if (dir_rows[i].has_fixed && expected_masses.size() != 0 &&
          expected_masses[$] !== dir_rows[i].fixed) begin
        $display("%0t table row %0d expected %0d/%0b, predictor %0d/%0b", $time, i,
                 dir_rows[i].fixed.mass, dir_rows[i].fixed.dropped,
                 expected_masses[$].mass, expected_masses[$].dropped);
        table_errors++;
      end
    end
    n_items = dir_rows.size();

    // Store full: 18 passing jets in one event, two dropped.
    for (int k = 0; k < 18; k++) begin
      one_jet = rand_jet(k == 17, 0);
      one_jet.pt = 11'd1000;
      send_jet(one_jet);
    end
    n_items += 18;

    // Pause until all results are back, then sweep the threshold extremes.
    drain();
    set_threshold(11'd0);
    for (int k = 0; k < 3; k++) send_jet(rand_jet(k == 2, 1));
    drain();
    set_threshold(11'd2047);
    one_jet = '{11'd2046, 16'd0, 16'd0, 16'd0, 16'd7, 1'b0};
    send_jet(one_jet);
    one_jet = '{11'd2047, 16'd0, 16'd0, 16'd0, 16'd7, 1'b1};
    send_jet(one_jet);
    n_items += 5;
    drain();
    set_threshold(11'd60);

    // Random events; change threshold between phases.
    for (int phase = 0; phase < 4; phase++) begin
      sink_busy = (phase == 1);
      src_busy  = (phase == 1);
      while (n_items < 140 * (phase + 1)) begin
        ev_len = ($urandom_range(9) == 0) ? $urandom_range(24, 17) : $urandom_range(6, 1);
        for (int k = 0; k < ev_len; k++) begin
          send_jet(rand_jet(k == ev_len - 1, $urandom_range(7) == 0));
          n_items++;
        end
        // Occasional stray jet ahead of an event.
        if ($urandom_range(15) == 0) begin
          send_jet(rand_jet(0, 1));
          n_items++;
        end
      end
      drain();
      set_threshold((phase == 2) ? 11'($urandom_range(2047)) : 11'($urandom_range(250)));
    end
    sink_busy = 0; src_busy = 0;

    // Close any open event so nothing is left half-built.
    send_jet(rand_jet(1, 0));
    drain();

    $display("Covered %0d jets in %0d events, %0d results checked, threshold 0..2047.",
             n_items + 1, events_sent, results_seen);
    if (errors == 0 && table_errors == 0 && expected_masses.size() == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end
endmodule

FILE: sim.f
+incdir+hdl
hdl/dmim_pkg.sv
hdl/dmim_front.sv
hdl/dmim_queue.sv
hdl/dmim_back.sv
hdl/dijet_max_invariant_mass.sv
hdl/dmim_checker.sv
bench/tb_top.sv
